/* sv/sorted_table_binary_search_top_macros.svh */
// Assertion macros shared by the checker of the sorted table search block.
// Depends on nothing; included by the checker file.
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SBS_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted table search: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define SBS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted table search: next-cycle check failed");

`endif

/* sv/sbs_pkg.sv */
// Shared types and constants for the sorted table search block.
// Used by the controller, the datapath, the top level and the checker.
package sbs_pkg;

  localparam int INDEX_W = 10;
  localparam int WORD_W  = 32;

  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef struct packed {
    logic                     mode;
    logic [INDEX_W-1:0]       entry_index;
    logic signed [WORD_W-1:0] entry_value;
    logic [INDEX_W-1:0]       range_low;
    logic [INDEX_W-1:0]       range_high;
    logic signed [WORD_W-1:0] search_key;
  } item_t;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] match_index;
  } result_t;

  typedef struct packed {
    logic write;
    logic start;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic finish;
  } status_t;

endpackage

/* sv/sbs_ctrl.sv */
// Controller state machine of the sorted table search block.
// Depends on sbs_pkg; drives the datapath through cmd_t and reads status_t.
module sbs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  logic             item_mode,
  output logic             item_stall,
  output logic             result_valid,
  input  logic             result_stall,
  input  sbs_pkg::status_t status,
  output sbs_pkg::cmd_t    cmd
);
  import sbs_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_RESULT = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign item_stall = (state != ST_IDLE);
  assign accept     = item_valid && (state == ST_IDLE);

  always_comb begin
    cmd.write    = accept && (item_mode == MODE_WRITE);
    cmd.start    = accept && (item_mode == MODE_SEARCH);
    cmd.step     = (state == ST_SEARCH);
    cmd.out_load = (state == ST_RESULT) && (!result_valid || !result_stall);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.start) begin
          state_next = status.empty ? ST_RESULT : ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (status.finish) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (cmd.out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/sbs_datapath.sv */
// Datapath of the sorted table search block: table memory, bounds and result.
// Depends on sbs_pkg; commanded by sbs_ctrl through cmd_t.
module sbs_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  sbs_pkg::item_t   item,
  input  sbs_pkg::cmd_t    cmd,
  output sbs_pkg::status_t status,
  output sbs_pkg::result_t result
);
  import sbs_pkg::*;

  localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SUM_W  = INDEX_W + 1;

  logic [WORD_W-1:0]        mem [TABLE_DEPTH];
  logic signed [WORD_W-1:0] rdata;
  logic signed [WORD_W-1:0] key;
  logic [INDEX_W-1:0]       lo;
  logic [INDEX_W-1:0]       hi;
  logic [INDEX_W-1:0]       mid;
  logic                     found;
  logic [INDEX_W-1:0]       index;

  logic [INDEX_W-1:0] hi_sat;
  logic [SUM_W-1:0]   sum_start;
  logic [INDEX_W-1:0] mid_start;
  logic               eq;
  logic               gt;
  logic [INDEX_W-1:0] lo_upd;
  logic [INDEX_W-1:0] hi_upd;
  logic [SUM_W-1:0]   sum_upd;
  logic [INDEX_W-1:0] mid_upd;
  logic [INDEX_W-1:0] probe_idx;
  logic               write_ok;

  always_comb begin
    hi_sat = (32'(item.range_high) > 32'(TABLE_DEPTH - 1)) ?
             INDEX_W'(TABLE_DEPTH - 1) : item.range_high;
    sum_start = SUM_W'(item.range_low) + SUM_W'(hi_sat);
    mid_start = sum_start[SUM_W-1:1];

    eq     = (rdata == key);
    gt     = (rdata > key);
    lo_upd = (!eq && !gt) ? (mid + INDEX_W'(1)) : lo;
    hi_upd = gt ? (mid - INDEX_W'(1)) : hi;
    sum_upd = SUM_W'(lo_upd) + SUM_W'(hi_upd);
    mid_upd = sum_upd[SUM_W-1:1];

    priority if (cmd.start) begin
      probe_idx = mid_start;
    end else if (cmd.step) begin
      probe_idx = mid_upd;
    end else begin
      probe_idx = mid;
    end

    write_ok      = 32'(item.entry_index) < 32'(TABLE_DEPTH);
    status.empty  = (item.range_low > hi_sat);
    status.finish = eq || (gt && (mid == lo)) || (!eq && !gt && (mid == hi));
  end

  always_ff @(posedge clk) begin
    if (cmd.write && write_ok) begin
      mem[ADDR_W'(item.entry_index)] <= item.entry_value;
    end
    rdata <= mem[ADDR_W'(probe_idx)];
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      lo    <= item.range_low;
      hi    <= hi_sat;
      mid   <= mid_start;
      key   <= item.search_key;
      found <= 1'b0;
      index <= '0;
    end else if (cmd.step) begin
      if (eq) begin
        found <= 1'b1;
        index <= mid;
      end else begin
        lo  <= lo_upd;
        hi  <= hi_upd;
        mid <= mid_upd;
      end
    end
    if (cmd.out_load) begin
      result.found       <= found;
      result.match_index <= index;
    end
  end

endmodule

/* sv/sorted_table_binary_search_top.sv */
// Top level of the sorted table search block; uses sbs_pkg, sbs_ctrl and sbs_datapath.
// A search makes one table probe per cycle, up to floor(log2(span)) + 1 probes (11 for 1024
// entries), then enters a result state that loads the result registers once the output is not
// stalled; result_valid rises after that load and the next item is taken back in the idle state.
// An empty range goes straight to the result state without a probe; a write gives no result.
// Synchronous active-high reset clears control state; table contents stay undefined.
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_stall,
  input  sbs_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_stall,
  output sbs_pkg::result_t result
);
  import sbs_pkg::*;

  cmd_t    cmd;
  status_t status;

  sbs_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_mode    (item.mode),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .status       (status),
    .cmd          (cmd)
  );

  sbs_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk    (clk),
    .item   (item),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

endmodule

/* sv/sbs_checker.sv */
// Port-level checker for the sorted table search block, bound to the top level.
// Depends on sbs_pkg and sorted_table_binary_search_top_macros.svh.
`include "sorted_table_binary_search_top_macros.svh"

module sbs_checker (
  input logic             clk,
  input logic             rst,
  input logic             item_valid,
  input logic             item_stall,
  input sbs_pkg::item_t   item,
  input logic             result_valid,
  input logic             result_stall,
  input sbs_pkg::result_t result
);
  import sbs_pkg::*;

  `SBS_ASSERT_NEXT(a_result_hold, clk, rst, result_valid && result_stall, result_valid && $stable(result))
  `SBS_ASSERT_IMPL(a_miss_index_zero, clk, rst, result_valid && !result.found, result.match_index == '0)
  `SBS_ASSERT_NEXT(a_search_busy, clk, rst, item_valid && !item_stall && (item.mode == MODE_SEARCH), item_stall)
  `SBS_ASSERT_IMPL(a_result_after_search, clk, rst, $rose(result_valid), $past(item_stall))

endmodule

bind sorted_table_binary_search_top sbs_checker u_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .item         (item),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
